// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time pixel core.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  // integer bits of the signed fixed-point format (sign included)
  localparam int INT_BITS = 8;

  // escape radius squared, integer part
  localparam int ESCAPE_SQ = 4;

  // full-scale gray level
  localparam int GRAY_FULL = 255;
  localparam int GRAY_BITS = 8;

  // configuration register index
  typedef logic [2:0] reg_index_t;

  localparam reg_index_t REG_MAX_ITER    = 3'd0;
  localparam reg_index_t REG_HALF_WIDTH  = 3'd1;
  localparam reg_index_t REG_HALF_HEIGHT = 3'd2;
  localparam reg_index_t REG_STEP_X      = 3'd3;
  localparam reg_index_t REG_STEP_Y      = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/mbe_iter_unit.sv -----
// ----------------------------------------------------------------------------
// mbe_iter_unit
// Shared complex-square unit: registered products, then escape test and
// saturated update of z.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_iter_unit #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                                         clk,
  input  wire logic                                         mul_en,
  input  wire logic signed [FRAC_BITS+mbe_pkg::INT_BITS-1:0] re,
  input  wire logic signed [FRAC_BITS+mbe_pkg::INT_BITS-1:0] im,
  input  wire logic signed [FRAC_BITS+mbe_pkg::INT_BITS-1:0] c_re,
  input  wire logic signed [FRAC_BITS+mbe_pkg::INT_BITS-1:0] c_im,
  output logic                                              escape,
  output logic signed [FRAC_BITS+mbe_pkg::INT_BITS-1:0]      re_next,
  output logic signed [FRAC_BITS+mbe_pkg::INT_BITS-1:0]      im_next
);
  import mbe_pkg::*;

  localparam int QW = FRAC_BITS + INT_BITS;
  localparam int PW = 2 * QW;
  localparam int PR = PW - FRAC_BITS;   // truncated product width
  localparam int SW = PR + 2;           // update sum width

  localparam logic signed [PR:0] FOUR =
    {{(PR - FRAC_BITS - 2){1'b0}}, 3'(ESCAPE_SQ), {FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0] SAT_HI = {{(SW - QW + 1){1'b0}}, {(QW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW - QW + 1){1'b1}}, {(QW - 1){1'b0}}};
  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW - 1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW - 1){1'b0}}};

  logic signed [PW-1:0] prod_rr;
  logic signed [PW-1:0] prod_ii;
  logic signed [PW-1:0] prod_ri;
  logic signed [PR-1:0] rr;
  logic signed [PR-1:0] ii;
  logic signed [PR-1:0] ri;
  logic signed [PR:0]   mag;
  logic signed [SW-1:0] re_sum;
  logic signed [SW-1:0] im_sum;

  assign prod_rr = PW'(re) * PW'(re);
  assign prod_ii = PW'(im) * PW'(im);
  assign prod_ri = PW'(re) * PW'(im);

  // floor toward minus infinity: drop the fraction of the exact product
  always_ff @(posedge clk) begin
    if (mul_en) begin
      rr <= prod_rr[PW-1:FRAC_BITS];
      ii <= prod_ii[PW-1:FRAC_BITS];
      ri <= prod_ri[PW-1:FRAC_BITS];
    end
  end

  always_comb begin
    mag    = (PR + 1)'(rr) + (PR + 1)'(ii);
    escape = (mag >= FOUR);
    re_sum = SW'(rr) - SW'(ii) + SW'(c_re);
    im_sum = SW'(ri) + SW'(ri) + SW'(c_im);

    if (re_sum > SAT_HI)      re_next = QMAX;
    else if (re_sum < SAT_LO) re_next = QMIN;
    else                      re_next = re_sum[QW-1:0];

    if (im_sum > SAT_HI)      im_next = QMAX;
    else if (im_sum < SAT_LO) im_next = QMIN;
    else                      im_next = im_sum[QW-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/mbe_divider.sv -----
// ----------------------------------------------------------------------------
// mbe_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_divider #(
  parameter int ITER_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [ITER_BITS+8:0]  dividend,
  input  wire logic [ITER_BITS-1:0]  divisor,
  output logic                       done,
  output logic [ITER_BITS+8:0]       quotient
);

  localparam int NW = ITER_BITS + 9;
  localparam int CW = $clog2(NW + 1);

  logic [ITER_BITS-1:0] rem;
  logic [ITER_BITS:0]   shifted;
  logic [ITER_BITS:0]   diff;
  logic [CW-1:0]        cnt;

  assign shifted = {rem, quotient[NW-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt      <= CW'(NW);
        rem      <= '0;
        quotient <= dividend;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) done <= 1'b1;
        if (shifted >= {1'b0, divisor}) begin
          rem      <= diff[ITER_BITS-1:0];
          quotient <= {quotient[NW-2:0], 1'b1};
        end else begin
          rem      <= shifted[ITER_BITS-1:0];
          quotient <= {quotient[NW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_time_pixel_core.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core
// Escape-time evaluator for one pixel, with count and gray-level result.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result is out. The result is shown for one cycle with done high
// and cannot be held off, so capture it on that edge. Each iteration passes
// through the multiplier bank and then through the add/compare/saturate
// step, and the gray level comes out of a serial divider that yields one
// bit per cycle (ITER_BITS + 9 bits). The iteration limit resets to 200.
// Configuration is written through cfg_we/cfg_index/cfg_data with no wait;
// write only while the core is idle. Unknown indices are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel_core #(
  parameter int COORD_BITS = 11,
  parameter int ITER_BITS  = 10,
  parameter int FRAC_BITS  = 24,
  localparam int CFG_W_A   = (FRAC_BITS + 1 > COORD_BITS) ? FRAC_BITS + 1 : COORD_BITS,
  localparam int CFG_W     = (CFG_W_A > ITER_BITS) ? CFG_W_A : ITER_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // request
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [COORD_BITS-1:0]     pixel_x,
  input  wire logic [COORD_BITS-1:0]     pixel_y,
  // result
  output logic                           done,
  output logic [ITER_BITS-1:0]           iteration_count,
  output logic [7:0]                     gray_level,
  output logic [23:0]                    pixel_color,
  // configuration
  input  wire logic                      cfg_we,
  input  wire mbe_pkg::reg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);
  import mbe_pkg::*;

  localparam int QW     = FRAC_BITS + INT_BITS;
  localparam int STEP_W = FRAC_BITS + 1;
  localparam int NW     = ITER_BITS + 9;
  localparam int MW     = COORD_BITS + FRAC_BITS + INT_BITS + 3;

  // reset step is 0.00625 per pixel, scaled to the fraction width
  localparam longint STEP_RST = (FRAC_BITS >= 24) ? (64'd104858 << (FRAC_BITS - 24))
                                                  : (64'd104858 >> (24 - FRAC_BITS));

  localparam logic signed [MW-1:0] SAT_HI = {{(MW - QW + 1){1'b0}}, {(QW - 1){1'b1}}};
  localparam logic signed [MW-1:0] SAT_LO = {{(MW - QW + 1){1'b1}}, {(QW - 1){1'b0}}};
  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW - 1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW - 1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_MUL,
    S_UPD,
    S_DIV_START,
    S_DIV_WAIT
  } state_t;

  state_t state;

  // configuration registers
  logic [ITER_BITS-1:0]  max_iterations;
  logic [COORD_BITS-1:0] half_width;
  logic [COORD_BITS-1:0] half_height;
  logic [STEP_W-1:0]     step_x;
  logic [STEP_W-1:0]     step_y;

  // per-request working registers
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [QW-1:0]       c_re;
  logic signed [QW-1:0]       c_im;
  logic signed [QW-1:0]       re;
  logic signed [QW-1:0]       im;
  logic [ITER_BITS-1:0]       count;
  logic [ITER_BITS-1:0]       limit;

  logic signed [MW-1:0] map_re;
  logic signed [MW-1:0] map_im;
  logic signed [QW-1:0] c_re_next;
  logic signed [QW-1:0] c_im_next;

  logic                 more;
  logic                 mul_en;
  logic                 escape;
  logic signed [QW-1:0] re_next;
  logic signed [QW-1:0] im_next;
  logic [NW-1:0]        numer;
  logic                 div_start;
  logic                 div_done;
  logic [NW-1:0]        quotient;
  logic [7:0]           gray;

  // config writes; low bits of the data word only
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= ITER_BITS'(200);
      half_width     <= COORD_BITS'(250);
      half_height    <= COORD_BITS'(225);
      step_x         <= STEP_W'(STEP_RST);
      step_y         <= STEP_W'(STEP_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ITER:    max_iterations <= cfg_data[ITER_BITS-1:0];
        REG_HALF_WIDTH:  half_width     <= cfg_data[COORD_BITS-1:0];
        REG_HALF_HEIGHT: half_height    <= cfg_data[COORD_BITS-1:0];
        REG_STEP_X:      step_x         <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:      step_y         <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel to c, saturated to the fixed-point range
  always_comb begin
    map_re = MW'(dx) * MW'($signed({1'b0, step_x}));
    map_im = MW'(dy) * MW'($signed({1'b0, step_y}));

    if (map_re > SAT_HI)      c_re_next = QMAX;
    else if (map_re < SAT_LO) c_re_next = QMIN;
    else                      c_re_next = map_re[QW-1:0];

    if (map_im > SAT_HI)      c_im_next = QMAX;
    else if (map_im < SAT_LO) c_im_next = QMIN;
    else                      c_im_next = map_im[QW-1:0];
  end

  assign more      = (count < limit);
  assign mul_en    = (state == S_MUL) && more;
  assign div_start = (state == S_DIV_START);
  assign busy      = (state != S_IDLE);

  // ceil(count*255/limit) as (count*256 - count + limit - 1) / limit;
  // count and limit hold still while the divider loads
  assign numer = {1'b0, count, 8'd0} - NW'(count) + NW'(limit) - NW'(1);

  mbe_iter_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk     (clk),
    .mul_en  (mul_en),
    .re      (re),
    .im      (im),
    .c_re    (c_re),
    .c_im    (c_im),
    .escape  (escape),
    .re_next (re_next),
    .im_next (im_next)
  );

  mbe_divider #(
    .ITER_BITS (ITER_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numer),
    .divisor  (limit),
    .done     (div_done),
    .quotient (quotient)
  );

  // zero limit forces gray to zero
  assign gray = (limit == '0) ? 8'd0 : quotient[7:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            dx    <= $signed({1'b0, pixel_x}) - $signed({1'b0, half_width});
            dy    <= $signed({1'b0, pixel_y}) - $signed({1'b0, half_height});
            limit <= max_iterations;
            state <= S_MAP;
          end
        end
        S_MAP: begin
          c_re  <= c_re_next;
          c_im  <= c_im_next;
          re    <= '0;
          im    <= '0;
          count <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (more) state <= S_UPD;
          else      state <= S_DIV_START;
        end
        S_UPD: begin
          if (escape) begin
            state <= S_DIV_START;
          end else begin
            re    <= re_next;
            im    <= im_next;
            count <= count + 1'b1;
            state <= S_MUL;
          end
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            iteration_count <= count;
            gray_level      <= gray;
            pixel_color     <= {gray, gray, gray};
            done            <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mbe_checker.sv -----
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks of the escape-time pixel core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_checker #(
  parameter int ITER_BITS = 10
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire logic [ITER_BITS-1:0] iteration_count,
  input wire logic [7:0]           gray_level,
  input wire logic [23:0]          pixel_color
);

  // an accepted request makes the core busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting a request");

  // a result only follows a busy cycle and frees the core
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe without a request in flight");

  // gray is zero exactly when no iteration was done
  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> ((gray_level == 8'd0) == (iteration_count == '0)))
    else $error("gray level disagrees with iteration count");

  a_color: assert property (@(posedge clk) disable iff (rst)
    done |-> (pixel_color == {gray_level, gray_level, gray_level}))
    else $error("packed color is not the replicated gray level");

endmodule

bind mandelbrot_escape_time_pixel_core mbe_checker #(
  .ITER_BITS (ITER_BITS)
) u_mbe_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .iteration_count (iteration_count),
  .gray_level      (gray_level),
  .pixel_color     (pixel_color)
);

`default_nettype wire

// ----- bench/mandelbrot_escape_time_pixel_core_test.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core_test
// Self-checking bench for the escape-time pixel core.
// ----------------------------------------------------------------------------
// Pixel requests are queued by the stimulus process and presented by a clocked
// driver on start/pixel_x/pixel_y. Each accepted request is run through a
// local escape-time predictor (Q8.24, floor products, saturating c and z)
// against the bench's own copy of the registers. The clocked monitor checks
// every done pulse against the oldest prediction. Register writes happen only
// with the core drained. A short directed set comes first, then random
// settings with pixels mostly aimed near the mapped origin.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core_test;
  import mbe_pkg::*;

  localparam int CB    = 11;
  localparam int IB    = 10;
  localparam int FB    = 24;
  localparam int CFG_W = 25;

  localparam longint Q_MAX    = (longint'(1) << (FB + INT_BITS - 1)) - 1;
  localparam longint Q_MIN    = -Q_MAX - 1;
  localparam longint FOUR_Q   = longint'(ESCAPE_SQ) << FB;
  // 2.25 in Q8.24: half-span of the interesting region around the origin
  localparam int ESCAPE_REACH = 9 << (FB - 2);

  // worst-case bound on one request, taken with the iteration count at the 10-bit limit
  localparam int SLOWEST_REQUEST = 2 * 1023 + IB + 14;
  localparam int WATCHDOG_CYCLES = 4 * SLOWEST_REQUEST;
  localparam int IDLE_PERCENT    = 11;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_PIXELS    = 125;

  // index that no register answers to; writes there must be dropped
  localparam reg_index_t REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } pixel_request_t;

  typedef struct packed {
    logic [IB-1:0] count;
    logic [7:0]    gray;
    logic [23:0]   color;
  } pixel_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [CB-1:0]     pixel_x = '0;
  logic [CB-1:0]     pixel_y = '0;
  logic              cfg_we = 1'b0;
  reg_index_t        cfg_index = REG_MAX_ITER;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              busy;
  logic              done;
  logic [IB-1:0]     iteration_count;
  logic [7:0]        gray_level;
  logic [23:0]       pixel_color;

  // bench copy of the register file, starts at reset values
  logic [IB-1:0]     iter_limit = 10'd200;
  logic [CB-1:0]     half_w = 11'd250;
  logic [CB-1:0]     half_h = 11'd225;
  logic [CFG_W-1:0]  step_x = 25'd104858;
  logic [CFG_W-1:0]  step_y = 25'd104858;

  pixel_request_t    pixel_requests[$];
  pixel_result_t     expected_pixels[$];
  pixel_request_t    in_hand;
  bit                holding = 1'b0;
  int                requests_taken = 0;
  int                mismatches = 0;
  int                quiet_cycles = 0;

  mandelbrot_escape_time_pixel_core #(
    .COORD_BITS(CB),
    .ITER_BITS (IB),
    .FRAC_BITS (FB)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .done           (done),
    .iteration_count(iteration_count),
    .gray_level     (gray_level),
    .pixel_color    (pixel_color),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // exact product, low FB bits dropped: arithmetic shift floors
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic pixel_result_t escape_time_of(logic [CB-1:0] px, logic [CB-1:0] py);
    longint        c_re, c_im, re, im, rr, ii, ri;
    int unsigned   n, g;
    bit            escaped;
    pixel_result_t r;
    c_re = clamp_q((longint'(px) - longint'(half_w)) * longint'(step_x));
    c_im = clamp_q((longint'(py) - longint'(half_h)) * longint'(step_y));
    re = 0;
    im = 0;
    n = 0;
    escaped = 1'b0;
    while (n < iter_limit && !escaped) begin
      rr = fx_mul(re, re);
      ii = fx_mul(im, im);
      // the sum is not limited before the compare
      if (rr + ii >= FOUR_Q) begin
        escaped = 1'b1;
      end else begin
        ri = fx_mul(re, im);
        im = clamp_q(ri + ri + c_im);
        re = clamp_q(rr - ii + c_re);
        n++;
      end
    end
    // zero limit: count stays 0 and gray is forced to 0
    g = (iter_limit == 0) ? 0 : (n * GRAY_FULL + iter_limit - 1) / iter_limit;
    r.count = n[IB-1:0];
    r.gray  = g[7:0];
    r.color = {g[7:0], g[7:0], g[7:0]};
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one request in hand at a time; start may drop at random even
  // while the core is busy, so gaps land on every phase of a computation.
  // A stretch of requests goes out with no gaps at all.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit calm;
    bit offer;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_pixels.push_back(escape_time_of(pixel_x, pixel_y));
        holding = 1'b0;
        requests_taken++;
      end
      if (!holding && pixel_requests.size() != 0) begin
        in_hand = pixel_requests.pop_front();
        holding = 1'b1;
      end
      calm  = requests_taken >= 300 && requests_taken < 450;
      offer = holding && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
      start   <= offer;
      pixel_x <= in_hand.x;
      pixel_y <= in_hand.y;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: results cannot be stalled, capture on the done edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result count %0d gray %0d color %06h", $time,
                 iteration_count, gray_level, pixel_color);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (iteration_count !== want.count) begin
          $display("%0t: iteration_count expected %0d actual %0d", $time,
                   want.count, iteration_count);
          mismatches++;
        end
        if (gray_level !== want.gray) begin
          $display("%0t: gray_level expected %0d actual %0d", $time,
                   want.gray, gray_level);
          mismatches++;
        end
        if (pixel_color !== want.color) begin
          $display("%0t: pixel_color expected %06h actual %06h", $time,
                   want.color, pixel_color);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without a request or a result taken
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_register(reg_index_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MAX_ITER:    iter_limit = val[IB-1:0];
      REG_HALF_WIDTH:  half_w = val[CB-1:0];
      REG_HALF_HEIGHT: half_h = val[CB-1:0];
      REG_STEP_X:      step_x = val;
      REG_STEP_Y:      step_y = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [IB-1:0] lim, logic [CB-1:0] hw, logic [CB-1:0] hh,
                               logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy);
    write_register(REG_MAX_ITER, CFG_W'(lim));
    write_register(REG_HALF_WIDTH, CFG_W'(hw));
    write_register(REG_HALF_HEIGHT, CFG_W'(hh));
    write_register(REG_STEP_X, sx);
    write_register(REG_STEP_Y, sy);
    @(negedge clk);
  endtask

  // core idle: nothing queued, nothing offered, nothing owed
  task automatic wait_drained();
    @(negedge clk);
    while (pixel_requests.size() != 0 || holding || expected_pixels.size() != 0 || busy)
      @(negedge clk);
  endtask

  task automatic queue_pixel(int x, int y);
    pixel_request_t p;
    p.x = x[CB-1:0];
    p.y = y[CB-1:0];
    pixel_requests.push_back(p);
  endtask

  // coordinate within about 2.25 of the mapped origin, clamped to the grid
  function automatic int near_center(logic [CB-1:0] mid, logic [CFG_W-1:0] step);
    int reach;
    int v;
    reach = (step == 0) ? 2047 : ESCAPE_REACH / int'(step);
    if (reach > 2047) reach = 2047;
    v = int'(mid) + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v;
  endfunction

  task automatic queue_random_pixels(int n);
    for (int i = 0; i < n; i++) begin
      // most points land where the orbit survives a while; the rest anywhere
      if ($urandom_range(0, 99) < 20)
        queue_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
      else
        queue_pixel(near_center(half_w, step_x), near_center(half_h, step_y));
    end
  endtask

  task automatic pick_random_setting();
    logic [IB-1:0]    lim;
    logic [CFG_W-1:0] sx;
    logic [CFG_W-1:0] sy;
    // long limits are kept rare: inside points run every iteration up to the limit
    if ($urandom_range(0, 3) == 0) lim = IB'($urandom_range(101, 400));
    else lim = IB'($urandom_range(1, 100));
    if ($urandom_range(0, 3) == 0) begin
      sx = CFG_W'($urandom_range(1, 1 << 24));
      sy = CFG_W'($urandom_range(1, 1 << 24));
    end else begin
      sx = CFG_W'($urandom_range(1 << 12, 1 << 20));
      sy = CFG_W'($urandom_range(1 << 12, 1 << 20));
    end
    apply_setting(lim, CB'($urandom_range(0, 2047)), CB'($urandom_range(0, 2047)), sx, sy);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: origin inside (full limit), corners, alternating bits
    queue_pixel(250, 225);
    queue_pixel(0, 0);
    queue_pixel(2047, 2047);
    queue_pixel(0, 2047);
    queue_pixel(2047, 0);
    queue_pixel(11'h555, 11'h2AA);
    queue_pixel(11'h2AA, 11'h555);
    wait_drained();

    // widest limit, fine step: points inside run all 1023 iterations
    apply_setting(10'd1023, 11'd1024, 11'd1024, 25'd1 << 20, 25'd1 << 20);
    queue_pixel(1024, 1024);
    queue_pixel(1020, 1024);
    queue_pixel(1032, 1024);
    wait_drained();

    // limit of one, unit step: far corner saturates c high
    apply_setting(10'd1, 11'd0, 11'd0, 25'd1 << 24, 25'd1 << 24);
    queue_pixel(0, 0);
    queue_pixel(2047, 2047);
    wait_drained();

    // zero limit, c saturated low at the near corner
    apply_setting(10'd0, 11'd2047, 11'd2047, 25'd1 << 24, 25'd1 << 24);
    queue_pixel(0, 0);
    queue_pixel(2047, 2047);
    wait_drained();

    // zero steps map every pixel to the origin; upper data bits above a
    // register's width are dropped, and a write to an unused index is ignored
    apply_setting(10'd50, 11'd1000, 11'd1000, 25'd0, 25'd0);
    write_register(REG_MAX_ITER, 25'h1FFFC00 | 25'd37);
    write_register(REG_HALF_WIDTH, 25'h1FFF800 | 25'd3);
    write_register(REG_UNUSED, 25'h1FFFFFF);
    @(negedge clk);
    queue_pixel(0, 2047);
    queue_pixel(1999, 3);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_random_setting();
      queue_random_pixels(PHASE_PIXELS);
      wait_drained();
    end

    // catch any stray done after the last result
    repeat (SLOWEST_REQUEST) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
